// ===== rtl/xsf_pkg.sv =====
package xsf_pkg;

   // screen geometry
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;

   // coordinates wrap at 8 bits before the screen wrap
   localparam int COORD_W     = 8;
   localparam int COORD_SPAN  = 1 << COORD_W;
   localparam int SPRITE_BITS = 8;
   localparam int STEP_W      = $clog2(SPRITE_BITS);

   localparam int COL_W = $clog2(SCREEN_WIDTH);
   localparam int ROW_W = $clog2(SCREEN_HEIGHT);

   // front to back queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CMD_DRAW  = 2'd0,
      CMD_CLEAR = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type                  op;
      logic [ROW_W-1:0]         row;
      logic [COORD_W-1:0]       pos_x;
      logic [SPRITE_BITS-1:0]   row_bits;
      logic                     last_row;
   } entry_type;

   typedef logic [COL_W-1:0] col_tab_type [COORD_SPAN];
   typedef logic [ROW_W-1:0] row_tab_type [COORD_SPAN];

   function automatic col_tab_type build_col_tab();
      col_tab_type t;
      for (int i = 0; i < COORD_SPAN; i++) begin
         t[i] = COL_W'(i % SCREEN_WIDTH);
      end
      return t;
   endfunction

   function automatic row_tab_type build_row_tab();
      row_tab_type t;
      for (int i = 0; i < COORD_SPAN; i++) begin
         t[i] = ROW_W'(i % SCREEN_HEIGHT);
      end
      return t;
   endfunction

   // wrapped 8-bit coordinate to screen column / row
   localparam col_tab_type COL_TAB = build_col_tab();
   localparam row_tab_type ROW_TAB = build_row_tab();

endpackage

// ===== rtl/xsf_if.sv =====
interface xsf_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [7:0] pos_x;
   logic [7:0] pos_y;
   logic [7:0] row_index;
   logic [7:0] row_bits;
   logic       last_row;

   modport source (output valid, command, pos_x, pos_y, row_index, row_bits, last_row,
                   input ready);
   modport sink   (input valid, command, pos_x, pos_y, row_index, row_bits, last_row,
                   output ready);
endinterface

interface xsf_rsp_if;
   logic       valid;
   logic       ready;
   logic       collision;
   logic [7:0] pixels_read;
   logic       sprite_done;

   modport source (output valid, collision, pixels_read, sprite_done, input ready);
   modport sink   (input valid, collision, pixels_read, sprite_done, output ready);
endinterface

// ===== rtl/xor_sprite_framebuffer_unit.sv =====
// channel | dir | beat carries
// --------+-----+----------------------------------------------------------
// req     | in  | command, pos_x, pos_y, row_index, row_bits, last_row
// rsp     | out | collision, pixels_read, sprite_done (one beat per req beat)
//
// Draw and read beats pass through the back end as pop, row fetch from the
// framebuffer RAM, eight pixel steps, then write-back (draw only) and result.
// Clear and unused commands go from pop straight to result.
// Reset is synchronous; per-row valid flags clear the picture at once, no sweep.
// A two-beat queue lets req keep arriving while the back end is busy; a
// stalled rsp holds the back end in its last step, and the queue then fills.
module xor_sprite_framebuffer_unit import xsf_pkg::*; (
   input logic       clock,
   input logic       reset,
   xsf_req_if.sink   req,
   xsf_rsp_if.source rsp
);

   // front to back queue handshake
   logic      q_valid;
   logic      q_ready;
   entry_type q_entry;

   // front: decode, row wrap, queue
   xsf_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_ready (q_ready)
   );

   // back: row fetch, per-pixel XOR or read, write-back, result register
   xsf_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_entry (q_entry),
      .q_ready (q_ready),
      .rsp     (rsp)
   );

endmodule

// ===== rtl/xsf_ram.sv =====
module xsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/xsf_front.sv =====
module xsf_front import xsf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   xsf_req_if.sink   req,
   output logic      q_valid,
   output entry_type q_entry,
   input  logic      q_ready
);

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   entry_type         entry;
   logic [COORD_W-1:0] row_sum;
   logic              push, pop;

   // decode and wrap the row once, on the way in
   always_comb begin
      row_sum        = COORD_W'(req.pos_y + req.row_index);
      entry.row      = ROW_TAB[row_sum];
      entry.pos_x    = req.pos_x;
      entry.row_bits = req.row_bits;
      entry.last_row = req.last_row;
      case (req.command)
         CMD_DRAW:  entry.op = CMD_DRAW;
         CMD_CLEAR: entry.op = CMD_CLEAR;
         CMD_READ:  entry.op = CMD_READ;
         default:   entry.op = CMD_NONE;
      endcase
   end

   assign req.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = slot_ff[rd_ptr_ff];
   assign pop       = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== rtl/xsf_back.sv =====
module xsf_back import xsf_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  entry_type q_entry,
   output logic      q_ready,
   xsf_rsp_if.source rsp
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_PIXEL,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   entry_type                cur_ff, cur_in;
   logic [SCREEN_WIDTH-1:0]  line_ff, line_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [SPRITE_BITS-1:0]   pix_ff, pix_in;
   logic                     coll_ff, coll_in;
   logic [SCREEN_HEIGHT-1:0] row_valid_ff, row_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_coll_ff, rsp_coll_in;
   logic [SPRITE_BITS-1:0]   rsp_pix_ff, rsp_pix_in;
   logic                     rsp_done_ff, rsp_done_in;

   logic                     ram_rd_en, ram_wr_en;
   logic [SCREEN_WIDTH-1:0]  ram_rd_data;
   logic [COORD_W-1:0]       col_sum;
   logic [COL_W-1:0]         col_sel;
   logic [STEP_W-1:0]        bit_sel;
   logic                     pix_old;
   logic                     out_free;

   xsf_ram #(
      .WIDTH (SCREEN_WIDTH),
      .DEPTH (SCREEN_HEIGHT)
   ) u_frame (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (cur_ff.row),
      .wr_data (line_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (q_entry.row),
      .rd_data (ram_rd_data)
   );

   // one pixel a step: column wrap by table, MSB of the sprite row first
   assign col_sum  = cur_ff.pos_x + COORD_W'(step_ff);
   assign col_sel  = COL_TAB[col_sum];
   assign bit_sel  = STEP_W'(SPRITE_BITS - 1) - step_ff;
   assign pix_old  = line_ff[col_sel];
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign q_ready  = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      line_in      = line_ff;
      step_in      = step_ff;
      pix_in       = pix_ff;
      coll_in      = coll_ff;
      row_valid_in = row_valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_coll_in  = rsp_coll_ff;
      rsp_pix_in   = rsp_pix_ff;
      rsp_done_in  = rsp_done_ff;
      ram_rd_en    = 1'b0;
      ram_wr_en    = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               cur_in = q_entry;
               case (q_entry.op)
                  CMD_DRAW, CMD_READ: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_FETCH;
                  end
                  CMD_CLEAR: begin
                     // rows read as blank until written again
                     row_valid_in = '0;
                     state_in     = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_FETCH: begin
            line_in  = row_valid_ff[cur_ff.row] ? ram_rd_data : '0;
            step_in  = '0;
            pix_in   = '0;
            state_in = ST_PIXEL;
         end
         ST_PIXEL: begin
            if (cur_ff.op == CMD_DRAW) begin
               if (cur_ff.row_bits[bit_sel]) begin
                  line_in[col_sel] = !pix_old;
                  if (pix_old) begin
                     coll_in = 1'b1;
                  end
               end
            end else begin
               pix_in[bit_sel] = pix_old;
            end
            if (step_ff == STEP_W'(SPRITE_BITS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_coll_in  = 1'b0;
               rsp_pix_in   = '0;
               rsp_done_in  = 1'b0;
               case (cur_ff.op)
                  CMD_DRAW: begin
                     ram_wr_en                 = 1'b1;
                     row_valid_in[cur_ff.row]  = 1'b1;
                     rsp_coll_in               = coll_ff;
                     rsp_done_in               = cur_ff.last_row;
                     if (cur_ff.last_row) begin
                        coll_in = 1'b0;
                     end
                  end
                  CMD_READ: begin
                     rsp_pix_in = pix_ff;
                  end
                  default: begin
                  end
               endcase
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      line_ff     <= line_in;
      step_ff     <= step_in;
      pix_ff      <= pix_in;
      rsp_coll_ff <= rsp_coll_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_done_ff <= rsp_done_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         coll_ff      <= 1'b0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         coll_ff      <= coll_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.collision   = rsp_coll_ff;
   assign rsp.pixels_read = rsp_pix_ff;
   assign rsp.sprite_done = rsp_done_ff;

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
   import xsf_pkg::*;

   // how the two sides hold back while a stretch of beats runs
   typedef enum logic [1:0] {
      IDLE_NONE = 2'd0,
      IDLE_SEND = 2'd1,
      IDLE_RECV = 2'd2,
      IDLE_BOTH = 2'd3
   } idle_mode_type;

   // one request beat plus the pacing that goes with it
   typedef struct {
      cmd_type       op;
      logic [7:0]    pos_x;
      logic [7:0]    pos_y;
      logic [7:0]    row_index;
      logic [7:0]    row_bits;
      logic          last_row;
      idle_mode_type mode;
      bit            drain_first;   // hold the beat back until nothing is due
   } sprite_cmd_type;

   typedef struct packed {
      logic       collision;
      logic [7:0] pixels_read;
      logic       sprite_done;
   } draw_outcome_type;

   localparam int SEND_GAP_PCT  = 48;
   localparam int RECV_STALL_PCT = 48;
   localparam int BOTH_PCT      = 18;
   localparam int RANDOM_BEATS  = 1300;
   localparam int TAIL_CYCLES   = 30;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   xsf_req_if req_ch ();
   xsf_rsp_if rsp_ch ();

   xor_sprite_framebuffer_unit u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // ------------------------------------------------------------------
   // Shadow of the block: the picture and the collision accumulator.
   // Both start cleared, as the block does out of reset.
   // ------------------------------------------------------------------
   bit [SCREEN_WIDTH-1:0] frame_px [SCREEN_HEIGHT];
   bit                    hit_flag;

   sprite_cmd_type   cmd_backlog [$];   // beats still to be offered on req
   draw_outcome_type due_results [$];   // outcomes owed on rsp, oldest first

   idle_mode_type fill_mode  = IDLE_NONE;
   bit            fill_drain = 1'b0;
   idle_mode_type run_mode   = IDLE_NONE;   // mode of the last beat taken
   bit            req_fired  = 1'b0;
   int            fault_count = 0;

   // Applies one accepted beat to the shadow picture and returns what the
   // block must answer. Both coordinates wrap at 8 bits first, then at the
   // screen edge; bit 7 of the row pattern is the leftmost pixel.
   function automatic draw_outcome_type render_beat(sprite_cmd_type c);
      draw_outcome_type o       = '0;
      logic [7:0]       wrap_y  = c.pos_y + c.row_index;
      int               row_sel = wrap_y % SCREEN_HEIGHT;
      logic [7:0]       wrap_x;
      int               col;
      case (c.op)
         CMD_DRAW: begin
            for (int k = 0; k < SPRITE_BITS; k++) begin
               if (c.row_bits[SPRITE_BITS-1-k]) begin
                  wrap_x = c.pos_x + 8'(k);
                  col    = wrap_x % SCREEN_WIDTH;
                  // erasing a lit pixel counts as a hit
                  if (frame_px[row_sel][col])
                     hit_flag = 1'b1;
                  frame_px[row_sel][col] = ~frame_px[row_sel][col];
               end
            end
            o.collision   = hit_flag;
            o.sprite_done = c.last_row;
            if (c.last_row)
               hit_flag = 1'b0;
         end
         CMD_CLEAR: begin
            // the accumulator survives a clear
            foreach (frame_px[r])
               frame_px[r] = '0;
         end
         CMD_READ: begin
            for (int k = 0; k < SPRITE_BITS; k++) begin
               wrap_x = c.pos_x + 8'(k);
               col    = wrap_x % SCREEN_WIDTH;
               o.pixels_read[SPRITE_BITS-1-k] = frame_px[row_sel][col];
            end
         end
         default: ;   // unused code: all-zero answer, nothing changes
      endcase
      return o;
   endfunction

   task automatic report_fault(string msg);
      fault_count++;
      if (fault_count <= 200)
         $display("%0t: mismatch: %s", $time, msg);
   endtask

   // ------------------------------------------------------------------
   // Beat builders
   // ------------------------------------------------------------------
   task automatic queue_cmd(cmd_type op, logic [7:0] x, logic [7:0] y,
                            logic [7:0] ri, logic [7:0] bits, logic last);
      sprite_cmd_type c;
      c.op          = op;
      c.pos_x       = x;
      c.pos_y       = y;
      c.row_index   = ri;
      c.row_bits    = bits;
      c.last_row    = last;
      c.mode        = fill_mode;
      c.drain_first = fill_drain;
      fill_drain    = 1'b0;
      cmd_backlog.push_back(c);
   endtask

   // Corners first: wrap at both 8-bit and screen edges, hits within one
   // sprite, empty rows, the unused code, a clear that keeps the
   // accumulator, and reads that ignore row_bits and last_row.
   task automatic fill_directed();
      queue_cmd(CMD_READ,  8'd0,   8'd0,   8'd0,   8'h00, 1'b0);
      queue_cmd(CMD_DRAW,  8'd0,   8'd0,   8'd0,   8'hFF, 1'b0);
      queue_cmd(CMD_DRAW,  8'd0,   8'd0,   8'd0,   8'h80, 1'b1);
      queue_cmd(CMD_READ,  8'd0,   8'd0,   8'd0,   8'h00, 1'b0);
      queue_cmd(CMD_DRAW,  8'd255, 8'd255, 8'd255, 8'hFF, 1'b1);
      queue_cmd(CMD_READ,  8'd255, 8'd255, 8'd255, 8'hFF, 1'b1);
      queue_cmd(CMD_DRAW,  8'd60,  8'd31,  8'd1,   8'hA5, 1'b0);
      queue_cmd(CMD_DRAW,  8'd60,  8'd31,  8'd1,   8'h5A, 1'b0);
      queue_cmd(CMD_DRAW,  8'd60,  8'd31,  8'd1,   8'h01, 1'b1);
      queue_cmd(CMD_READ,  8'd60,  8'd31,  8'd1,   8'h00, 1'b0);
      queue_cmd(CMD_DRAW,  8'd128, 8'd128, 8'd0,   8'h00, 1'b1);
      queue_cmd(CMD_DRAW,  8'd128, 8'd128, 8'd0,   8'h00, 1'b0);
      queue_cmd(CMD_NONE,  8'hFF,  8'hFF,  8'hFF,  8'hFF, 1'b1);
      queue_cmd(CMD_DRAW,  8'd0,   8'd0,   8'd0,   8'h40, 1'b0);
      queue_cmd(CMD_CLEAR, 8'hFF,  8'hFF,  8'hFF,  8'hFF, 1'b1);
      queue_cmd(CMD_DRAW,  8'd0,   8'd0,   8'd0,   8'h00, 1'b1);
      queue_cmd(CMD_READ,  8'd0,   8'd0,   8'd0,   8'h00, 1'b0);
      queue_cmd(CMD_READ,  8'd255, 8'd0,   8'd0,   8'h00, 1'b0);
      queue_cmd(CMD_DRAW,  8'd7,   8'd127, 8'd128, 8'h81, 1'b1);
      queue_cmd(CMD_READ,  8'd7,   8'd127, 8'd128, 8'h00, 1'b0);
      queue_cmd(CMD_NONE,  8'h00,  8'h00,  8'h00,  8'h00, 1'b0);
   endtask

   // Mostly whole sprites, often redrawn near the previous one so that hits
   // are common, with read-backs; the rest is clears, unused codes, lone rows
   // and sprites that never see their last row. Stretches of 100 beats cycle
   // through the idling modes, and each stretch opens on a drained pipe.
   task automatic fill_random();
      logic [7:0] sx;
      logic [7:0] sy;
      logic [7:0] bits;
      int         rows;
      int         pick;
      int         stretch;
      int         target;
      stretch = -1;
      sx      = 8'($urandom);
      sy      = 8'($urandom);
      target  = cmd_backlog.size() + RANDOM_BEATS;
      while (cmd_backlog.size() < target) begin
         if (cmd_backlog.size() / 100 != stretch) begin
            stretch    = cmd_backlog.size() / 100;
            fill_mode  = idle_mode_type'(stretch % 4);
            fill_drain = 1'b1;
         end
         if ($urandom_range(0, 9) < 4) begin
            sx = sx + 8'($urandom_range(0, 3));
            sy = sy + 8'($urandom_range(0, 2));
         end else begin
            sx = 8'($urandom);
            sy = 8'($urandom);
         end
         pick = $urandom_range(0, 99);
         if (pick < 55 || pick >= 93) begin
            rows = $urandom_range(1, 15);
            for (int r = 0; r < rows; r++) begin
               bits = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom);
               // a broken sprite never raises last_row
               queue_cmd(CMD_DRAW, sx, sy, 8'(r), bits, pick < 55 && r == rows - 1);
            end
            if ($urandom_range(0, 1))
               for (int r = 0; r < rows; r++)
                  queue_cmd(CMD_READ, sx, sy, 8'(r), 8'($urandom), 1'($urandom));
         end else if (pick < 75) begin
            queue_cmd(CMD_READ, sx, sy, 8'($urandom), 8'($urandom), 1'($urandom));
         end else if (pick < 80) begin
            queue_cmd(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'($urandom));
         end else if (pick < 85) begin
            queue_cmd(CMD_NONE, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'($urandom));
         end else begin
            queue_cmd(CMD_DRAW, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'($urandom));
         end
      end
   endtask

   // Per-beat pacing on the request side.
   function automatic bit send_gap(sprite_cmd_type c);
      if (c.drain_first && due_results.size() != 0)
         return 1'b1;
      case (c.mode)
         IDLE_SEND: return $urandom_range(0, 99) < SEND_GAP_PCT;
         IDLE_BOTH: return $urandom_range(0, 99) < BOTH_PCT;
         default:   return 1'b0;
      endcase
   endfunction

   function automatic bit recv_stall();
      case (run_mode)
         IDLE_RECV: return $urandom_range(0, 99) < RECV_STALL_PCT;
         IDLE_BOTH: return $urandom_range(0, 99) < BOTH_PCT;
         default:   return 1'b0;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Rising edge: take beats on both channels. A req beat is folded into
   // the shadow before any rsp beat of the same edge is checked, so the
   // order of the two never matters.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      draw_outcome_type want;
      req_fired <= !reset && req_ch.valid && req_ch.ready;
      if (!reset && req_ch.valid && req_ch.ready) begin
         run_mode = cmd_backlog[0].mode;
         due_results.push_back(render_beat(cmd_backlog.pop_front()));
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (due_results.size() == 0) begin
            report_fault($sformatf("rsp beat with nothing due (pixels %02h)",
                                   rsp_ch.pixels_read));
         end else begin
            want = due_results.pop_front();
            if (rsp_ch.collision !== want.collision)
               report_fault($sformatf("collision got %b want %b",
                                      rsp_ch.collision, want.collision));
            if (rsp_ch.pixels_read !== want.pixels_read)
               report_fault($sformatf("pixels_read got %02h want %02h",
                                      rsp_ch.pixels_read, want.pixels_read));
            if (rsp_ch.sprite_done !== want.sprite_done)
               report_fault($sformatf("sprite_done got %b want %b",
                                      rsp_ch.sprite_done, want.sprite_done));
         end
      end
   end

   // ------------------------------------------------------------------
   // Falling edge: drive. An offered beat stays put until it is taken.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!(req_ch.valid && !req_fired)) begin
         if (cmd_backlog.size() == 0 || send_gap(cmd_backlog[0])) begin
            req_ch.valid <= 1'b0;
         end else begin
            req_ch.valid     <= 1'b1;
            req_ch.command   <= cmd_backlog[0].op;
            req_ch.pos_x     <= cmd_backlog[0].pos_x;
            req_ch.pos_y     <= cmd_backlog[0].pos_y;
            req_ch.row_index <= cmd_backlog[0].row_index;
            req_ch.row_bits  <= cmd_backlog[0].row_bits;
            req_ch.last_row  <= cmd_backlog[0].last_row;
         end
      end
      rsp_ch.ready <= !recv_stall();
   end

   // ------------------------------------------------------------------
   // Sequence: fill, reset, drain, verdict.
   // ------------------------------------------------------------------
   initial begin
      req_ch.valid     = 1'b0;
      req_ch.command   = CMD_NONE;
      req_ch.pos_x     = '0;
      req_ch.pos_y     = '0;
      req_ch.row_index = '0;
      req_ch.row_bits  = '0;
      req_ch.last_row  = 1'b0;
      rsp_ch.ready     = 1'b0;
      fill_directed();
      fill_random();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      while (cmd_backlog.size() != 0 || due_results.size() != 0)
         @(posedge clock);
      // give the back end room to show a stray beat
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("PASS xor_sprite_framebuffer_unit");
      else
         $display("FAIL xor_sprite_framebuffer_unit");
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #3000000;
      $display("FAIL xor_sprite_framebuffer_unit");
      $finish;
   end

endmodule
